// ===== design/swlq_pkg.sv =====
// Shared types and constants for the sequence-number window link-quality block.
// Used by swlq_ctrl, swlq_datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package swlq_pkg;

  // Sequence number, window register, count and quality widths
  localparam int unsigned SeqW   = 16;
  localparam int unsigned WinW   = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned QualW  = 7;

  // Presence map: MapDepth slots (power of two), held as Rows words of RowBits
  localparam int unsigned MapDepth  = 256;
  localparam int unsigned PosW      = $clog2(MapDepth);
  localparam int unsigned RowBits   = 16;
  localparam int unsigned LaneW     = $clog2(RowBits);
  localparam int unsigned Rows      = MapDepth / RowBits;
  localparam int unsigned RowW      = $clog2(Rows);
  localparam int unsigned SweepCntW = $clog2(Rows + 1);
  localparam int unsigned SpanW     = $clog2(MapDepth + 1);
  localparam int unsigned PopW      = $clog2(RowBits + 1);

  // Quality = Percent * count / divisor, restoring division one bit per cycle
  localparam int unsigned Percent = 100;
  localparam int unsigned NumW    = $clog2(Percent * ((2 ** CountW) - 1) + 1);
  localparam int unsigned DivCntW = $clog2(NumW + 1);

  localparam logic [WinW-1:0] WinReset = WinW'(32);

  typedef enum logic [1:0] {
    StatusRecorded  = 2'd0,
    StatusDuplicate = 2'd1,
    StatusTooOld    = 2'd2
  } add_status_e;

  typedef enum logic [2:0] {
    StIdle,
    StDispatch,
    StSweep,
    StUpdate,
    StDivInit,
    StDivide,
    StDone
  } ctrl_state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;
    logic lookup_rd;
    logic sweep_step;
    logic update;
    logic div_init;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic first_item;
    logic advance;
    logic sweep_last;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/swlq_ctrl.sv =====
// Sequencing state machine for the link-quality block.
// Depends on swlq_pkg; drives swlq_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module swlq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  swlq_pkg::dp_status_t status_i,
  output swlq_pkg::dp_cmd_t    cmd_o
);
  import swlq_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StDispatch;
      end
      StDispatch: begin
        if (status_i.first_item || status_i.advance) state_d = StSweep;
        else state_d = StUpdate;
      end
      StSweep: begin
        if (status_i.sweep_last) state_d = StDivInit;
      end
      StUpdate:  state_d = StDivInit;
      StDivInit: state_d = StDivide;
      StDivide: begin
        if (status_i.div_last) state_d = StDone;
      end
      StDone: begin
        if (status_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle:     cmd_o.accept     = in_valid_i;
      StDispatch: cmd_o.lookup_rd  = 1'b1;  // row read for the in-window check
      StSweep:    cmd_o.sweep_step = 1'b1;
      StUpdate:   cmd_o.update     = 1'b1;
      StDivInit:  cmd_o.div_init   = 1'b1;
      StDivide:   cmd_o.div_step   = 1'b1;
      StDone:     cmd_o.out_load   = status_i.out_free;
      default:    cmd_o            = '0;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

// ===== design/swlq_datapath.sv =====
// Datapath: window register, presence map memory, head/count state, divider, output word.
// Depends on swlq_pkg; controlled by swlq_ctrl through dp_cmd_t / dp_status_t.
`timescale 1ns / 1ps

module swlq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [swlq_pkg::WinW-1:0]     cfg_data_i,
  input  logic [swlq_pkg::SeqW-1:0]     seq_number_i,
  input  swlq_pkg::dp_cmd_t             cmd_i,
  output swlq_pkg::dp_status_t          status_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [swlq_pkg::QualW-1:0]    quality_percent_o,
  output logic [swlq_pkg::CountW-1:0]   entries_held_o,
  output logic [1:0]                    add_status_o
);
  import swlq_pkg::*;

  // Window register and derived divisor / span
  logic [WinW-1:0]  win_q;
  logic [WinW-1:0]  divisor;
  logic [SpanW-1:0] span;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WinReset;
    end else if (cfg_valid_i) begin
      win_q <= cfg_data_i;
    end
  end

  assign divisor = (win_q == '0) ? WinW'(1) : win_q;
  assign span    = (SpanW'(divisor) > SpanW'(MapDepth)) ? SpanW'(MapDepth) : SpanW'(divisor);

  // Item and head state
  logic [SeqW-1:0]   seq_q;
  logic [SeqW-1:0]   newest_q;
  logic              nonempty_q;
  logic [CountW-1:0] held_q;
  add_status_e       status_q;
  logic [SeqW-1:0]   delta, behind;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) seq_q <= seq_number_i;
  end

  assign delta  = seq_q - newest_q;
  assign behind = newest_q - seq_q;

  // Presence map: slot = low bits of the sequence number, Rows words of RowBits
  logic [RowBits-1:0] map_mem [Rows];
  logic [RowBits-1:0] rd_data_q;
  logic [RowW-1:0]    rd_row_q;
  logic               mem_re, mem_we, sweep_rd;
  logic [RowW-1:0]    mem_raddr, mem_waddr;
  logic [RowBits-1:0] mem_wdata;

  // Sweep sequencing: read row n while writing back row n-1
  logic [SweepCntW-1:0] sweep_cnt_q;
  logic                 rd_vld_q;
  logic [SpanW-1:0]     acc_q;
  logic                 sweep_last;

  assign sweep_rd   = cmd_i.sweep_step && (sweep_cnt_q < SweepCntW'(Rows));
  assign sweep_last = (sweep_cnt_q == SweepCntW'(Rows));

  // Row rewrite for a head advance: keep what stays inside the span, set the new head
  logic [RowBits-1:0] sweep_row;
  logic [PopW-1:0]    sweep_pop;

  always_comb begin
    logic [PosW-1:0] slot;
    logic [PosW-1:0] pos;
    logic            keep;
    sweep_row = '0;
    sweep_pop = '0;
    for (int l = 0; l < RowBits; l++) begin
      slot = {rd_row_q, LaneW'(l)};
      pos  = seq_q[PosW-1:0] - slot;
      keep = !status_o.first_item && (SpanW'(pos) < span) && (SeqW'(pos) >= delta);
      sweep_row[l] = (pos == '0) | (keep & rd_data_q[l]);
    end
    for (int l = 0; l < RowBits; l++) begin
      sweep_pop = sweep_pop + PopW'(sweep_row[l]);
    end
  end

  // In-window lookup for a number that is not newer than the head
  logic too_old, dup, record_lk;

  assign too_old   = (behind >= SeqW'(span));
  assign dup       = rd_data_q[seq_q[LaneW-1:0]];
  assign record_lk = !too_old && !dup;

  // Memory port control
  always_comb begin
    mem_re    = sweep_rd || cmd_i.lookup_rd;
    mem_raddr = cmd_i.lookup_rd ? seq_q[PosW-1:LaneW] : sweep_cnt_q[RowW-1:0];
    mem_we    = 1'b0;
    mem_waddr = rd_row_q;
    mem_wdata = sweep_row;
    if (cmd_i.sweep_step && rd_vld_q) begin
      mem_we = 1'b1;
    end else if (cmd_i.update && record_lk) begin
      mem_we    = 1'b1;
      mem_waddr = seq_q[PosW-1:LaneW];
      mem_wdata = rd_data_q | (RowBits'(1) << seq_q[LaneW-1:0]);
    end
  end

  // Map memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= map_mem[mem_raddr];
    if (sweep_rd) rd_row_q <= sweep_cnt_q[RowW-1:0];
  end

  // Sweep counter and running count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
      rd_vld_q    <= 1'b0;
      acc_q       <= '0;
    end else if (cmd_i.accept) begin
      sweep_cnt_q <= '0;
      rd_vld_q    <= 1'b0;
      acc_q       <= '0;
    end else if (cmd_i.sweep_step) begin
      sweep_cnt_q <= sweep_cnt_q + SweepCntW'(1);
      rd_vld_q    <= sweep_rd;
      if (rd_vld_q) acc_q <= acc_q + SpanW'(sweep_pop);
    end
  end

  // Head, count and item status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q   <= '0;
      nonempty_q <= 1'b0;
      held_q     <= '0;
      status_q   <= StatusRecorded;
    end else if (cmd_i.sweep_step && sweep_last) begin
      newest_q   <= seq_q;
      nonempty_q <= 1'b1;
      held_q     <= CountW'(acc_q + SpanW'(sweep_pop));
      status_q   <= StatusRecorded;
    end else if (cmd_i.update) begin
      if (too_old) begin
        status_q <= StatusTooOld;
      end else if (dup) begin
        status_q <= StatusDuplicate;
      end else begin
        status_q <= StatusRecorded;
        held_q   <= held_q + CountW'(1);
      end
    end
  end

  // Restoring divider: Percent * held / divisor, one quotient bit per cycle
  logic [NumW-1:0]    quo_q;
  logic [WinW-1:0]    rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [WinW:0]      trial;
  logic               trial_ge;

  assign trial    = {rem_q, quo_q[NumW-1]};
  assign trial_ge = (trial >= (WinW+1)'(divisor));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      div_cnt_q <= DivCntW'(NumW);
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      quo_q <= NumW'(held_q) * NumW'(Percent);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[NumW-2:0], trial_ge};
      rem_q <= trial_ge ? WinW'(trial - (WinW+1)'(divisor)) : trial[WinW-1:0];
    end
  end

  // Output word register
  logic               out_valid_q;
  logic [QualW-1:0]   qual_out_q;
  logic [CountW-1:0]  held_out_q;
  add_status_e        status_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      qual_out_q   <= quo_q[QualW-1:0];
      held_out_q   <= held_q;
      status_out_q <= status_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign quality_percent_o = qual_out_q;
  assign entries_held_o    = held_out_q;
  assign add_status_o      = status_out_q;

  // Status back to the controller
  always_comb begin
    status_o.first_item = !nonempty_q;
    status_o.advance    = nonempty_q && (delta != '0) && !delta[SeqW-1];
    status_o.sweep_last = sweep_last;
    status_o.div_last   = (div_cnt_q == DivCntW'(1));
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

// ===== design/seqnum_window_link_quality.sv =====
// Path from input accept to output valid: when the item becomes the head, a 16-row read/write sweep
// of the presence map, then a 15-step divider; otherwise a single row read and update before the divider.
// One item in flight, with no new item taken until the output word is loaded; set by the map memory
// port (one 16-bit row per cycle) and the bit-serial quality divider.
// Reset (async, active low): window length 32, held count zero, map memory not reset; the first item clears the map.
`timescale 1ns / 1ps

module seqnum_window_link_quality (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swlq_pkg::WinW-1:0]   cfg_win_len_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [swlq_pkg::SeqW-1:0]   seq_number_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [swlq_pkg::QualW-1:0]  quality_percent_o,
  output logic [swlq_pkg::CountW-1:0] entries_held_o,
  output logic [1:0]                  add_status_o
);
  import swlq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Register writes always land
  assign cfg_ready_o = 1'b1;

  swlq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swlq_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_win_len_i),
    .seq_number_i      (seq_number_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .quality_percent_o (quality_percent_o),
    .entries_held_o    (entries_held_o),
    .add_status_o      (add_status_o)
  );

endmodule

// ===== design/swlq_checker.sv =====
// Port-level checks for seqnum_window_link_quality, attached by bind.
// Depends on swlq_pkg and the top level's ports.
`timescale 1ns / 1ps

module swlq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [swlq_pkg::QualW-1:0]  quality_percent_o,
  input logic [swlq_pkg::CountW-1:0] entries_held_o,
  input logic [1:0]                  add_status_o
);
  import swlq_pkg::*;

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(quality_percent_o)
      && $stable(entries_held_o) && $stable(add_status_o))
    else $error("output word changed under stall");

  // One item at a time: after an accept the input side stalls
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // Status code is always a defined one
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (add_status_o == StatusRecorded) || (add_status_o == StatusDuplicate)
      || (add_status_o == StatusTooOld))
    else $error("undefined add status");

  // Empty count means zero quality
  a_zero_quality: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (entries_held_o == '0) |-> (quality_percent_o == '0))
    else $error("nonzero quality with no entries held");

endmodule

bind seqnum_window_link_quality swlq_checker u_swlq_checker (.*);

// ===== sim/seqnum_window_link_quality_test.sv =====
// Self-checking testbench for seqnum_window_link_quality: sequence numbers go in, link reports
// come out and are checked against an in-bench window tracker. Depends on swlq_pkg and the RTL.
`timescale 1ns / 1ps

module seqnum_window_link_quality_test;

  typedef struct packed {
    logic [swlq_pkg::QualW-1:0]  quality;
    logic [swlq_pkg::CountW-1:0] held;
    swlq_pkg::add_status_e       status;
  } link_report_t;

  logic                        clk_i             = 1'b0;
  logic                        rst_ni            = 1'b0;
  logic                        cfg_valid_i       = 1'b0;
  logic                        cfg_ready_o;
  logic [swlq_pkg::WinW-1:0]   cfg_win_len_i     = '0;
  logic                        in_valid_i        = 1'b0;
  logic                        in_stall_o;
  logic [swlq_pkg::SeqW-1:0]   seq_number_i      = '0;
  logic                        out_valid_o;
  logic                        out_stall_i       = 1'b0;
  logic [swlq_pkg::QualW-1:0]  quality_percent_o;
  logic [swlq_pkg::CountW-1:0] entries_held_o;
  logic [1:0]                  add_status_o;

  // Words waiting to be sent, reports waiting to be seen
  logic [swlq_pkg::SeqW-1:0] seq_backlog[$];
  link_report_t              report_fifo[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned fail_count    = 0;

  // Window tracker state
  logic [swlq_pkg::MapDepth-1:0] seen_map   = '0;
  logic [swlq_pkg::SeqW-1:0]     head_seq   = '0;
  logic                          head_valid = 1'b0;
  logic [swlq_pkg::CountW-1:0]   held_cnt   = '0;
  logic [swlq_pkg::WinW-1:0]     window_reg = swlq_pkg::WinReset;

  // Stimulus generator cursor, roughly follows the head
  logic [swlq_pkg::SeqW-1:0] gen_cursor = '0;

  seqnum_window_link_quality u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_win_len_i     (cfg_win_len_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .seq_number_i      (seq_number_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .quality_percent_o (quality_percent_o),
    .entries_held_o    (entries_held_o),
    .add_status_o      (add_status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Update the window with one accepted number and queue the report it should produce
  task automatic track_seq(input logic [swlq_pkg::SeqW-1:0] seq);
    int unsigned               divisor;
    int unsigned               span;
    logic [swlq_pkg::SeqW-1:0] delta;
    logic [swlq_pkg::SeqW-1:0] behind;
    link_report_t              rep;
    divisor = (window_reg == 0) ? 1 : window_reg;
    span    = (divisor > swlq_pkg::MapDepth) ? swlq_pkg::MapDepth : divisor;
    delta   = seq - head_seq;
    behind  = head_seq - seq;
    if (!head_valid) begin
      seen_map    = '0;
      seen_map[0] = 1'b1;
      head_seq    = seq;
      head_valid  = 1'b1;
      held_cnt    = swlq_pkg::CountW'(1);
      rep.status  = swlq_pkg::StatusRecorded;
    end else if (delta >= 1 && delta <= 32767) begin
      // slide the map, drop everything at or past the span, recount
      seen_map = seen_map << delta;
      held_cnt = '0;
      for (int k = 0; k < swlq_pkg::MapDepth; k++) begin
        if (k >= span) seen_map[k] = 1'b0;
        else if (seen_map[k]) held_cnt++;
      end
      head_seq    = seq;
      seen_map[0] = 1'b1;
      held_cnt++;
      rep.status  = swlq_pkg::StatusRecorded;
    end else if (behind >= span) begin
      rep.status = swlq_pkg::StatusTooOld;
    end else if (seen_map[behind[swlq_pkg::PosW-1:0]]) begin
      rep.status = swlq_pkg::StatusDuplicate;
    end else begin
      seen_map[behind[swlq_pkg::PosW-1:0]] = 1'b1;
      held_cnt++;
      rep.status = swlq_pkg::StatusRecorded;
    end
    rep.held    = held_cnt;
    rep.quality = swlq_pkg::QualW'((100 * held_cnt) / divisor);
    report_fifo.push_back(rep);
  endtask

  // Sender: hold while stalled, otherwise maybe present the next word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      seq_number_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) track_seq(seq_number_i);
      if (!in_valid_i || !in_stall_o) begin
        if (seq_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i   <= 1'b1;
          seq_number_i <= seq_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall, compare every accepted report
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (report_fifo.size() == 0) begin
          $display("%0t: unexpected report q=%0d held=%0d status=%0d", $time,
                   quality_percent_o, entries_held_o, add_status_o);
          fail_count++;
        end else begin
          link_report_t want;
          want = report_fifo.pop_front();
          if (quality_percent_o !== want.quality) begin
            $display("%0t: quality_percent expected %0d actual %0d", $time,
                     want.quality, quality_percent_o);
            fail_count++;
          end
          if (entries_held_o !== want.held) begin
            $display("%0t: entries_held expected %0d actual %0d", $time,
                     want.held, entries_held_o);
            fail_count++;
          end
          if (add_status_o !== want.status) begin
            $display("%0t: add_status expected %0d actual %0d", $time,
                     want.status, add_status_o);
            fail_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Write the window register; the tracker takes the new value on the handshake
  task automatic write_window(input logic [swlq_pkg::WinW-1:0] w);
    @(posedge clk_i);
    cfg_valid_i   <= 1'b1;
    cfg_win_len_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    window_reg  = w;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait until every queued word is sent and every report seen, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    while (seq_backlog.size() != 0 || in_valid_i || report_fifo.size() != 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Mostly near the head: forward steps, late arrivals, jumps; some half-circle and noise
  function automatic logic [swlq_pkg::SeqW-1:0] next_seq(input int unsigned w);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      gen_cursor = swlq_pkg::SeqW'(gen_cursor + $urandom_range(1, 3));
      return gen_cursor;
    end else if (pick < 80) begin
      return swlq_pkg::SeqW'(gen_cursor - $urandom_range(0, w + 1));
    end else if (pick < 88) begin
      gen_cursor = swlq_pkg::SeqW'(gen_cursor + $urandom_range((w < 2) ? 1 : w - 1, 32767));
      return gen_cursor;
    end else if (pick < 93) begin
      return gen_cursor + 16'd32768;
    end
    return swlq_pkg::SeqW'($urandom);
  endfunction

  task automatic random_phase(input logic [swlq_pkg::WinW-1:0] w, input int unsigned idle,
                              input int unsigned stall, input int unsigned n,
                              input bit pause_midway);
    drain();
    write_window(w);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      seq_backlog.push_back(next_seq((w == 0) ? 1 : w));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, default window of 32: empty window, duplicate, late arrival,
    // half-circle distance, drop at the span edge, large jump, max forward step
    seq_backlog.push_back(16'd0);
    seq_backlog.push_back(16'd0);
    seq_backlog.push_back(16'd1);
    seq_backlog.push_back(16'd65535);
    seq_backlog.push_back(16'd32769);
    seq_backlog.push_back(16'd31);
    seq_backlog.push_back(16'd0);
    seq_backlog.push_back(16'd33);
    seq_backlog.push_back(16'd100);
    seq_backlog.push_back(16'd32867);
    seq_backlog.push_back(16'd100);
    seq_backlog.push_back(16'd32836);
    seq_backlog.push_back(16'd32835);
    drain();

    // Window shrunk to 1 below the held count, then window zero
    write_window(8'd1);
    seq_backlog.push_back(16'd32867);
    seq_backlog.push_back(16'd5);
    seq_backlog.push_back(16'd5);
    seq_backlog.push_back(16'd4);
    seq_backlog.push_back(16'd6);
    drain();
    write_window(8'd0);
    seq_backlog.push_back(16'd6);
    seq_backlog.push_back(16'd7);
    seq_backlog.push_back(16'd6);
    drain();

    // Widest window filled solid across the wrap, then mixed traffic
    write_window(8'd255);
    gen_cursor = 16'hFF80;
    for (int i = 0; i < 260; i++) begin
      seq_backlog.push_back(gen_cursor);
      gen_cursor++;
    end
    for (int i = 0; i < 60; i++) seq_backlog.push_back(next_seq(255));

    random_phase(8'd32, 78, 0, 80, 1'b0);
    random_phase(8'd7, 0, 78, 80, 1'b0);
    random_phase(8'd200, 18, 18, 80, 1'b1);
    random_phase(8'd3, 18, 18, 30, 1'b0);
    random_phase(8'd1, 0, 0, 20, 1'b0);
    random_phase(8'd100, 0, 0, 20, 1'b0);
    drain();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
